/* rtl/rsa_pkg.sv */
// Shared constants, register indexes and state types of the RSA exponentiation engine.
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

   localparam int MOD_BITS_DEF   = 32;
   localparam int PRIME_BITS_DEF = 16;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIME_P     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIME_Q     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PUBLIC_EXP  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIVATE_EXP = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXP_MOD_P   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXP_MOD_Q   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Q_INVERSE   = 3'd7;

   localparam logic [1:0] OP_ENCRYPT = 2'd0;
   localparam logic [1:0] OP_DECRYPT = 2'd1;
   localparam logic [1:0] OP_CRT     = 2'd2;

   localparam int RST_PRIME_P     = 2;
   localparam int RST_PRIME_Q     = 3;
   localparam int RST_MODULUS     = 6;
   localparam int RST_PUBLIC_EXP  = 17;
   localparam int RST_PRIVATE_EXP = 1;
   localparam int RST_EXP_MOD_P   = 0;
   localparam int RST_EXP_MOD_Q   = 0;
   localparam int RST_Q_INVERSE   = 0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXP_INIT,
      ST_RED,
      ST_EXP_BIT,
      ST_MUL,
      ST_EXP_END,
      ST_DIFF,
      ST_PROD,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_MAIN,
      PH_P,
      PH_Q,
      PH_B
   } phase_type;

   typedef enum logic [1:0] {
      MK_ACC,
      MK_SQR,
      MK_T
   } mul_kind_type;

endpackage

`default_nettype wire

/* rtl/rsa_crt_modexp_engine.sv */
// Top level of the RSA modular exponentiation engine with plain and CRT decryption.
`timescale 1ns / 1ps
`default_nettype none

// One word in, one word out; the engine takes a new word only after the last result
// has left. Square-and-multiply runs least significant exponent bit first, and each
// modular multiply runs add-and-double on two shared modular adders, one multiplier
// bit per cycle, stopping when the remaining multiplier bits are zero. An
// exponentiation first reduces the base modulo its modulus, then runs up to 2*k
// multiplies for a k-bit exponent; CRT mode runs two exponentiations, mod p and
// mod q, then one reduction of the second result mod p, one multiply mod p and a
// recombination through a product and a sum. Key registers may be written only
// while the engine is idle (csr_ready high).
module rsa_crt_modexp_engine #(
   parameter int MOD_BITS   = rsa_pkg::MOD_BITS_DEF,
   parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic [MOD_BITS-1:0]                   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [MOD_BITS-1:0]                   rsp_result,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rsa_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [((MOD_BITS > PRIME_BITS) ? MOD_BITS : PRIME_BITS)-1:0] csr_wdata
);

   import rsa_pkg::*;

   localparam int W         = (MOD_BITS > PRIME_BITS) ? MOD_BITS : PRIME_BITS;
   localparam int PW        = 2 * PRIME_BITS;
   localparam int SW        = (PW > MOD_BITS) ? PW : MOD_BITS;
   localparam int CNT_BITS  = $clog2(W);

   logic [PRIME_BITS-1:0] prime_p_ff, prime_p_in;
   logic [PRIME_BITS-1:0] prime_q_ff, prime_q_in;
   logic [MOD_BITS-1:0]   modulus_ff, modulus_in;
   logic [MOD_BITS-1:0]   pub_exp_ff, pub_exp_in;
   logic [MOD_BITS-1:0]   priv_exp_ff, priv_exp_in;
   logic [PRIME_BITS-1:0] exp_p_ff, exp_p_in;
   logic [PRIME_BITS-1:0] exp_q_ff, exp_q_in;
   logic [PRIME_BITS-1:0] qinv_ff, qinv_in;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   mul_kind_type kind_ff, kind_in;

   logic [1:0]          op_ff, op_in;
   logic [MOD_BITS-1:0] v_ff, v_in;
   logic [W-1:0]        mod_ff, mod_in;
   logic [W-1:0]        ex_ff, ex_in;
   logic [W-1:0]        base_ff, base_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        mx_ff, mx_in;
   logic [W-1:0]        my_ff, my_in;
   logic [W-1:0]        macc_ff, macc_in;
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        dvd_ff, dvd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W-1:0]        m1_ff, m1_in;
   logic [W-1:0]        m2_ff, m2_in;
   logic [W-1:0]        t_ff, t_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [MOD_BITS-1:0] res_ff, res_in;

   logic [W-1:0]  la_s;
   logic [W-1:0]  lb_x;
   logic          lb_cin;
   logic [W-1:0]  lb_s;
   logic [W-1:0]  mod_sel;
   logic [W-1:0]  ex_sel;
   logic [W-1:0]  ex_shift;
   logic [W-1:0]  t_val;
   logic [SW-1:0] sum_val;

   rsa_addmod #(.WIDTH(W)) u_lane_a (
      .x   (macc_ff),
      .y   (mx_ff),
      .cin (1'b0),
      .m   (mod_ff),
      .s   (la_s)
   );

   rsa_addmod #(.WIDTH(W)) u_lane_b (
      .x   (lb_x),
      .y   (lb_x),
      .cin (lb_cin),
      .m   (mod_ff),
      .s   (lb_s)
   );

   assign lb_x      = (state_ff == ST_RED) ? rem_ff : mx_ff;
   assign lb_cin    = (state_ff == ST_RED) ? dvd_ff[W-1] : 1'b0;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result = res_ff;
   assign csr_ready = (state_ff == ST_IDLE);

   // key register writes
   always_comb begin
      prime_p_in  = prime_p_ff;
      prime_q_in  = prime_q_ff;
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      exp_p_in    = exp_p_ff;
      exp_q_in    = exp_q_ff;
      qinv_in     = qinv_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRIME_P:     prime_p_in  = csr_wdata[PRIME_BITS-1:0];
            CSR_PRIME_Q:     prime_q_in  = csr_wdata[PRIME_BITS-1:0];
            CSR_MODULUS:     modulus_in  = csr_wdata[MOD_BITS-1:0];
            CSR_PUBLIC_EXP:  pub_exp_in  = csr_wdata[MOD_BITS-1:0];
            CSR_PRIVATE_EXP: priv_exp_in = csr_wdata[MOD_BITS-1:0];
            CSR_EXP_MOD_P:   exp_p_in    = csr_wdata[PRIME_BITS-1:0];
            CSR_EXP_MOD_Q:   exp_q_in    = csr_wdata[PRIME_BITS-1:0];
            CSR_Q_INVERSE:   qinv_in     = csr_wdata[PRIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_MAIN: begin
            mod_sel = W'(modulus_ff);
            ex_sel  = (op_ff == OP_DECRYPT) ? W'(priv_exp_ff) : W'(pub_exp_ff);
         end
         PH_P: begin
            mod_sel = W'(prime_p_ff);
            ex_sel  = W'(exp_p_ff);
         end
         default: begin
            mod_sel = W'(prime_q_ff);
            ex_sel  = W'(exp_q_ff);
         end
      endcase
   end

   assign ex_shift = ex_ff >> 1;
   assign t_val    = m1_ff - rem_ff + ((m1_ff < rem_ff) ? mod_ff : '0);
   assign sum_val  = SW'(m2_ff) + SW'(prod_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      op_in    = op_ff;
      v_in     = v_ff;
      mod_in   = mod_ff;
      ex_in    = ex_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      macc_in  = macc_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      t_in     = t_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               v_in  = req_value;
               unique case (req_operation) inside
                  OP_ENCRYPT, OP_DECRYPT: begin
                     phase_in = PH_MAIN;
                     state_in = ST_EXP_INIT;
                  end
                  OP_CRT: begin
                     phase_in = PH_P;
                     state_in = ST_EXP_INIT;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end

         ST_EXP_INIT: begin
            mod_in = mod_sel;
            ex_in  = ex_sel;
            if (ex_sel == '0) begin
               acc_in   = W'(1);
               state_in = ST_EXP_END;
            end else if (mod_sel < W'(2)) begin
               acc_in   = '0;
               state_in = ST_EXP_END;
            end else begin
               acc_in   = W'(1);
               dvd_in   = W'(v_ff);
               rem_in   = '0;
               cnt_in   = CNT_BITS'(W - 1);
               state_in = ST_RED;
            end
         end

         ST_RED: begin
            rem_in = lb_s;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               if (phase_ff == PH_B) begin
                  state_in = ST_DIFF;
               end else begin
                  base_in  = lb_s;
                  state_in = ST_EXP_BIT;
               end
            end
         end

         ST_EXP_BIT: begin
            if (ex_ff == '0) begin
               state_in = ST_EXP_END;
            end else if (ex_ff[0]) begin
               mx_in    = base_ff;
               my_in    = acc_ff;
               macc_in  = '0;
               kind_in  = MK_ACC;
               state_in = ST_MUL;
            end else begin
               ex_in = ex_shift;
               if (ex_shift == '0) begin
                  state_in = ST_EXP_END;
               end else begin
                  mx_in    = base_ff;
                  my_in    = base_ff;
                  macc_in  = '0;
                  kind_in  = MK_SQR;
                  state_in = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            if (my_ff == '0) begin
               unique case (kind_ff)
                  MK_ACC: begin
                     acc_in   = macc_ff;
                     ex_in    = {ex_ff[W-1:1], 1'b0};
                     state_in = ST_EXP_BIT;
                  end
                  MK_SQR: begin
                     base_in  = macc_ff;
                     state_in = ST_EXP_BIT;
                  end
                  default: begin
                     t_in     = macc_ff;
                     state_in = ST_PROD;
                  end
               endcase
            end else begin
               if (my_ff[0]) begin
                  macc_in = la_s;
               end
               mx_in = lb_s;
               my_in = my_ff >> 1;
            end
         end

         ST_EXP_END: begin
            unique case (phase_ff)
               PH_MAIN: begin
                  res_in   = acc_ff[MOD_BITS-1:0];
                  state_in = ST_OUT;
               end
               PH_P: begin
                  m1_in    = acc_ff;
                  phase_in = PH_Q;
                  state_in = ST_EXP_INIT;
               end
               PH_Q: begin
                  m2_in = acc_ff;
                  if (W'(prime_p_ff) < W'(2)) begin
                     t_in     = '0;
                     state_in = ST_PROD;
                  end else begin
                     mod_in   = W'(prime_p_ff);
                     dvd_in   = acc_ff;
                     rem_in   = '0;
                     cnt_in   = CNT_BITS'(W - 1);
                     phase_in = PH_B;
                     state_in = ST_RED;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         ST_DIFF: begin
            mx_in    = t_val;
            my_in    = W'(qinv_ff);
            macc_in  = '0;
            kind_in  = MK_T;
            state_in = ST_MUL;
         end

         ST_PROD: begin
            prod_in  = PW'(t_ff[PRIME_BITS-1:0]) * PW'(prime_q_ff);
            state_in = ST_SUM;
         end

         ST_SUM: begin
            res_in   = sum_val[MOD_BITS-1:0];
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_MAIN;
         kind_ff     <= MK_ACC;
         prime_p_ff  <= PRIME_BITS'(RST_PRIME_P);
         prime_q_ff  <= PRIME_BITS'(RST_PRIME_Q);
         modulus_ff  <= MOD_BITS'(RST_MODULUS);
         pub_exp_ff  <= MOD_BITS'(RST_PUBLIC_EXP);
         priv_exp_ff <= MOD_BITS'(RST_PRIVATE_EXP);
         exp_p_ff    <= PRIME_BITS'(RST_EXP_MOD_P);
         exp_q_ff    <= PRIME_BITS'(RST_EXP_MOD_Q);
         qinv_ff     <= PRIME_BITS'(RST_Q_INVERSE);
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         prime_p_ff  <= prime_p_in;
         prime_q_ff  <= prime_q_in;
         modulus_ff  <= modulus_in;
         pub_exp_ff  <= pub_exp_in;
         priv_exp_ff <= priv_exp_in;
         exp_p_ff    <= exp_p_in;
         exp_q_ff    <= exp_q_in;
         qinv_ff     <= qinv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      v_ff    <= v_in;
      mod_ff  <= mod_in;
      ex_ff   <= ex_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      macc_ff <= macc_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cnt_ff  <= cnt_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine took a second word while busy");

   a_mul_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (macc_ff < mod_ff) && (mx_ff < mod_ff))
      else $error("multiply operand not reduced");

   a_red_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED) |-> (rem_ff < mod_ff) && (mod_ff >= W'(2)))
      else $error("reduction remainder out of range");

   a_exp_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_BIT) |-> (acc_ff < mod_ff) && (base_ff < mod_ff))
      else $error("exponentiation operand not reduced");

endmodule

`default_nettype wire

/* rtl/rsa_addmod.sv */
// Modular add lane: (x + y + cin) mod m for x, y below m.
`timescale 1ns / 1ps
`default_nettype none

module rsa_addmod #(
   parameter int WIDTH = rsa_pkg::MOD_BITS_DEF
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic             cin,
   input  logic [WIDTH-1:0] m,
   output logic [WIDTH-1:0] s
);

   logic [WIDTH:0] sum;
   logic [WIDTH:0] diff;

   always_comb begin
      sum  = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
      diff = sum - {1'b0, m};
      s    = (sum >= {1'b0, m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
   end

endmodule

`default_nettype wire
